/* rtl/pidl_pkg.sv */
package pidl_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int WORD_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_READ      = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_MID   = 3'd4,
        CMD_DEL_LAST  = 3'd5,
        CMD_INSERT    = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_READ
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [WORD_W-1:0]  value;
    } t_cell_cmd;

endpackage

/* rtl/pidl_cell.sv */
module pidl_cell
    import pidl_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [WORD_W-1:0] i_left,
    input  logic [WORD_W-1:0] i_right,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_rd_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              hit;
    logic              above;

    assign hit   = (i_idx == MY_IDX);
    assign above = (MY_IDX > i_idx);

    // An insert moves every word above the slot one place up, a remove pulls
    // every word from the slot on one place down.
    always_comb begin
        n_word = r_word;
        unique case (i_cmd.op)
            CELL_WRITE: begin
                if (hit) n_word = i_cmd.value;
            end
            CELL_INSERT: begin
                if (hit) n_word = i_cmd.value;
                else if (above) n_word = i_left;
            end
            CELL_REMOVE: begin
                if (hit || above) n_word = i_right;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = (i_cmd.op == CELL_READ && hit) ? r_word : '0;

endmodule

/* rtl/pidl_ctrl.sv */
module pidl_ctrl
    import pidl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int POS_W = $clog2(CAPACITY + 2),
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [WORD_W-1:0] i_value,
    output t_cell_cmd         o_cell,
    output logic [IDX_W-1:0]  o_idx,
    output t_status           o_status,
    output logic [CNT_W-1:0]  o_count
);

    localparam int CMP_W = POS_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic [CMP_W-1:0] used_x;
    logic [CMP_W-1:0] pos_x;
    t_cell_op         op;

    assign used_x = CMP_W'(r_used);
    assign pos_x  = CMP_W'(i_pos);

    always_comb begin
        n_used   = r_used;
        o_status = ST_OK;
        op       = CELL_HOLD;
        o_idx    = '0;
        unique case (t_cmd'(i_cmd)) inside
            CMD_CLEAR: begin
                n_used = '0;
            end
            CMD_APPEND: begin
                if (r_used == CAP_CNT) begin
                    o_status = ST_FULL;
                end else begin
                    op     = CELL_WRITE;
                    o_idx  = r_used[IDX_W-1:0];
                    n_used = r_used + 1'b1;
                end
            end
            CMD_READ: begin
                if (r_used == '0) begin
                    o_status = ST_EMPTY;
                end else if (pos_x >= used_x) begin
                    o_status = ST_BADPOS;
                end else begin
                    op    = CELL_READ;
                    o_idx = i_pos[IDX_W-1:0];
                end
            end
            CMD_DEL_FIRST, CMD_DEL_MID, CMD_DEL_LAST: begin
                if (r_used == '0) begin
                    o_status = ST_EMPTY;
                end else begin
                    n_used = r_used - 1'b1;
                    if (t_cmd'(i_cmd) == CMD_DEL_FIRST) begin
                        op = CELL_REMOVE;
                    end else if (t_cmd'(i_cmd) == CMD_DEL_MID) begin
                        op    = CELL_REMOVE;
                        o_idx = IDX_W'(r_used >> 1);
                    end
                end
            end
            CMD_INSERT: begin
                if (r_used == CAP_CNT) begin
                    o_status = ST_FULL;
                end else if (pos_x == '0 || pos_x > used_x + 1'b1) begin
                    o_status = ST_BADPOS;
                end else begin
                    op     = CELL_INSERT;
                    o_idx  = IDX_W'(i_pos - 1'b1);
                    n_used = r_used + 1'b1;
                end
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    assign o_cell.op    = i_fire ? op : CELL_HOLD;
    assign o_cell.value = i_value;
    assign o_count      = n_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_fire) begin
            r_used <= n_used;
        end
    end

endmodule

/* rtl/pidl_obuf.sv */
module pidl_obuf #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_can_push,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_v0;
    logic         r_v1;
    logic [W-1:0] r_d0;
    logic [W-1:0] r_d1;
    logic         n_v0;
    logic         n_v1;
    logic [W-1:0] n_d0;
    logic [W-1:0] n_d1;
    logic         pop;

    assign pop        = r_v0 && i_ready;
    assign o_can_push = !r_v1;
    assign o_valid    = r_v0;
    assign o_data     = r_d0;

    // A push only comes while the second slot is free.
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (pop) begin
            if (r_v1) begin
                n_d0 = r_d1;
                n_v1 = 1'b0;
            end else begin
                n_v0 = i_push;
                n_d0 = i_data;
            end
        end else if (i_push) begin
            if (r_v0) begin
                n_v1 = 1'b1;
                n_d1 = i_data;
            end else begin
                n_v0 = 1'b1;
                n_d0 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

/* rtl/positional_insert_delete_list.sv */
// The result of a command beat is registered into the result queue when the beat is taken.
// Throughput: one command per cycle while the queue has room; the two-entry queue keeps
// taking commands while one result waits, and the slave side stalls only when both are held.
// Reset (synchronous, active low) empties the list and the result queue.
// The stored words are not cleared and need no clearing pass; no word is read unwritten.
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CNT_W  = $clog2(CAPACITY + 1),
    localparam int POS_W  = $clog2(CAPACITY + 2),
    localparam int IN_DW  = ((POS_W + WORD_W + 7) / 8) * 8,
    localparam int OUT_DW = ((CNT_W + WORD_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // position, value, zero fill
    input  logic [CMD_W-1:0]  s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // count, read_value, zero fill
    output logic [STATUS_W-1:0] m_axis_tuser  // status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int RES_W = STATUS_W + CNT_W + WORD_W;

    logic                     fire;
    logic                     can_push;
    logic [POS_W-1:0]         in_pos;
    logic signed [WORD_W-1:0] in_value;
    t_cell_cmd                cell_cmd;
    logic [IDX_W-1:0]         cell_idx;
    t_status                  status;
    logic [CNT_W-1:0]         count;
    logic [WORD_W-1:0]        words   [CAPACITY];
    logic [WORD_W-1:0]        rd_part [CAPACITY];
    logic signed [WORD_W-1:0] rd_word;
    logic [RES_W-1:0]         res_in;
    logic [RES_W-1:0]         res_out;

    // A command beat is taken whenever the result queue has room.
    assign s_axis_tready = can_push;
    assign fire          = s_axis_tvalid && can_push;

    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = s_axis_tdata[POS_W +: WORD_W];

    // The controller holds the word count, checks the command against it and
    // turns it into one operation and one slot index for the whole chain.
    pidl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (s_axis_tuser),
        .i_pos    (in_pos),
        .i_value  (in_value),
        .o_cell   (cell_cmd),
        .o_idx    (cell_idx),
        .o_status (status),
        .o_count  (count)
    );

    // One cell per list slot. Each cell compares its own index with the
    // broadcast slot and takes the new word, its lower neighbor's word or its
    // upper neighbor's word, so every cell of an insert or delete shift moves together.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = words[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = words[g];
        end else begin : g_inner_r
            assign right = words[g+1];
        end

        pidl_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cell_cmd),
            .i_idx     (cell_idx),
            .i_left    (left),
            .i_right   (right),
            .o_word    (words[g]),
            .o_rd_word (rd_part[g])
        );
    end

    // Only the addressed cell drives a nonzero word during a read, so the
    // read data is the OR of all cell contributions.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | rd_part[i];
        end
    end

    // The count sits in the low bits of the result data, the read word above it.
    assign res_in = {status, rd_word, count};

    pidl_obuf #(
        .W (RES_W)
    ) u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (fire),
        .i_data     (res_in),
        .o_can_push (can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (res_out)
    );

    assign m_axis_tuser = res_out[RES_W-1 -: STATUS_W];
    assign m_axis_tdata = OUT_DW'(res_out[CNT_W+WORD_W-1:0]);

endmodule

/* rtl/pidl_checker.sv */
module pidl_checker
    import pidl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CNT_W  = $clog2(CAPACITY + 1),
    localparam int OUT_DW = ((CNT_W + WORD_W + 7) / 8) * 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_DW-1:0]   m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] rdv;

    assign cnt = m_axis_tdata[CNT_W-1:0];
    assign rdv = m_axis_tdata[CNT_W +: WORD_W];

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> cnt == '0)
        else $error("empty status with nonzero count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |-> cnt == CNT_W'(CAPACITY))
        else $error("full status below capacity");

    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && rdv != '0 |-> m_axis_tuser == ST_OK)
        else $error("read word present on a failed command");

endmodule

bind positional_insert_delete_list pidl_checker #(.CAPACITY(CAPACITY)) u_pidl_checker (.*);

/* sim/pidl_list_checker.sv */
module pidl_list_checker
    import pidl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [39:0] i_cmd_data,   // position, value, zero fill
    input  logic [2:0]  i_cmd_user,   // cmd
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,   // count, read_value, zero fill
    input  logic [1:0]  i_res_user,   // status
    output int          o_pending,
    output int          o_list_len,
    output int          o_fail_count
);

    // Watches both streams of the list block, keeps a shadow copy of the list,
    // and checks every result beat against the oldest predicted result.

    localparam int LIST_CAP = DEF_CAPACITY;
    localparam int CNT_W    = $clog2(LIST_CAP + 1);
    localparam int POS_W    = $clog2(LIST_CAP + 2);

    typedef struct {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [WORD_W-1:0]  read_value;
    } t_list_result;

    logic [WORD_W-1:0] list_words [LIST_CAP];
    int                list_used;
    t_list_result      pending_results [$];
    int                mismatch_count;

    // Applies one command to the shadow list and returns the result it must produce.
    task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                      input logic [POS_W-1:0] pos,
                                      input logic [WORD_W-1:0] val,
                                      output t_list_result res);
        int i;
        int idx;
        res.status     = ST_OK;
        res.read_value = '0;
        case (cmd)
            CMD_CLEAR: begin
                list_used = 0;
            end
            CMD_APPEND: begin
                if (list_used >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_used] = val;
                    list_used++;
                end
            end
            CMD_READ: begin
                if (list_used == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= list_used) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.read_value = list_words[pos];
                end
            end
            CMD_DEL_FIRST, CMD_DEL_MID, CMD_DEL_LAST: begin
                if (list_used == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_DEL_FIRST) begin
                        idx = 0;
                    end else if (cmd == CMD_DEL_MID) begin
                        idx = list_used / 2;
                    end else begin
                        idx = list_used - 1;
                    end
                    for (i = idx; i + 1 < list_used; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_used--;
                end
            end
            CMD_INSERT: begin
                if (list_used >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else if (int'(pos) < 1 || int'(pos) > list_used + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = list_used; i >= int'(pos); i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos - 1] = val;
                    list_used++;
                end
            end
            default: begin
                // Unused codes leave the list alone and report ok.
            end
        endcase
        res.count = CNT_W'(list_used);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            list_used = 0;
            pending_results.delete();
        end else begin
            // Results first: a command beat taken at this edge cannot answer yet.
            if (i_res_valid && i_res_ready) begin
                got.status     = t_status'(i_res_user);
                got.count      = i_res_data[CNT_W-1:0];
                got.read_value = i_res_data[CNT_W +: WORD_W];
                if (pending_results.size() == 0) begin
                    $error("result beat with no command waiting: status %0d count %0d",
                           got.status, got.count);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, got.count);
                        mismatch_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        mismatch_count++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_list_command(i_cmd_user, i_cmd_data[POS_W-1:0],
                                   i_cmd_data[POS_W +: WORD_W], want);
                pending_results.push_back(want);
            end
        end
        o_pending    <= pending_results.size();
        o_list_len   <= list_used;
        o_fail_count <= mismatch_count;
    end

endmodule

/* sim/tb_positional_insert_delete_list.sv */
module tb_positional_insert_delete_list;
    import pidl_pkg::*;

    // Stimulus and verdict for the list block; all checking lives in the checkers.

    localparam int LIST_CAP    = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1530;
    localparam int LONG_HOLD   = 200;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef enum {PH_GROW, PH_MIX, PH_SHRINK} t_phase_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_tdata = '0;    // position, value, zero fill
    logic [2:0]  s_tuser = '0;    // cmd
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_tdata;         // count, read_value, zero fill
    logic [1:0]  m_tuser;         // status

    int  pending;
    int  list_len;
    int  fail_count;
    int  cycle_count = 0;
    bit  steady = 1'b0;           // no random idling on either side while set
    bit  hold_request = 1'b0;

    always #2 i_clk = ~i_clk;

    positional_insert_delete_list u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    pidl_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_valid),
        .i_cmd_ready  (s_ready),
        .i_cmd_data   (s_tdata),
        .i_cmd_user   (s_tuser),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_tdata),
        .i_res_user   (m_tuser),
        .o_pending    (pending),
        .o_list_len   (list_len),
        .o_fail_count (fail_count)
    );

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    // Offers one command beat and returns at the edge where it is taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [5:0] pos,
                             input logic [WORD_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {2'b00, val, pos};
        s_tuser <= cmd;
        do @(posedge i_clk); while (!s_ready);
    endtask

    // Stops offering beats until every predicted result has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly legal indexes for the current length, sometimes any position from 0 to LIST_CAP + 1.
    function automatic logic [5:0] pick_position(logic [CMD_W-1:0] cmd, int len);
        if ($urandom_range(0, 9) < 8) begin
            if (cmd == CMD_READ && len > 0) begin
                return $urandom_range(0, len - 1);
            end
            if (cmd == CMD_INSERT) begin
                return $urandom_range(1, len + 1);
            end
        end
        return $urandom_range(0, LIST_CAP + 1);
    endfunction

    function automatic logic [CMD_W-1:0] pick_delete();
        case ($urandom_range(0, 2))
            0:       return CMD_DEL_FIRST;
            1:       return CMD_DEL_MID;
            default: return CMD_DEL_LAST;
        endcase
    endfunction

    // Grow phases favour appends and inserts, shrink phases favour deletes.
    function automatic logic [CMD_W-1:0] pick_cmd(t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 96) begin
            return ($urandom_range(0, 2) == 0) ? CMD_UNUSED : CMD_CLEAR;
        end
        case (kind)
            PH_GROW: begin
                if (r < 40) return CMD_APPEND;
                if (r < 72) return CMD_INSERT;
                if (r < 86) return CMD_READ;
                return pick_delete();
            end
            PH_SHRINK: begin
                if (r < 10) return CMD_APPEND;
                if (r < 20) return CMD_INSERT;
                if (r < 38) return CMD_READ;
                return pick_delete();
            end
            default: begin
                if (r < 20) return CMD_APPEND;
                if (r < 40) return CMD_INSERT;
                if (r < 65) return CMD_READ;
                return pick_delete();
            end
        endcase
    endfunction

    // Result side: a random stall before each beat, or one long hold-off on request.
    initial begin : receiver
        int stall;
        forever begin
            stall = hold_request ? LONG_HOLD : draw_gap();
            hold_request = 1'b0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int          sent;
        int          phase_num;
        int          phase_len;
        t_phase_kind kind;
        logic [CMD_W-1:0] cmd;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads, deletes and bad inserts on an empty list, then edge positions and values.
        send_beat(CMD_READ,      6'd0,  32'd0);
        send_beat(CMD_DEL_FIRST, 6'd0,  32'd0);
        send_beat(CMD_DEL_MID,   6'd0,  32'd0);
        send_beat(CMD_DEL_LAST,  6'd0,  32'd0);
        send_beat(CMD_INSERT,    6'd0,  32'd5);
        send_beat(CMD_INSERT,    6'd2,  32'd5);
        send_beat(CMD_INSERT,    6'd1,  32'h7FFF_FFFF);
        send_beat(CMD_APPEND,    6'd63, 32'h8000_0000);
        send_beat(CMD_INSERT,    6'd3,  32'hFFFF_FFFF);
        send_beat(CMD_INSERT,    6'd1,  32'h0000_0000);
        send_beat(CMD_INSERT,    6'd33, 32'h1234_5678);
        send_beat(CMD_READ,      6'd0,  32'd0);
        send_beat(CMD_READ,      6'd3,  32'd0);
        send_beat(CMD_READ,      6'd4,  32'd0);
        send_beat(CMD_READ,      6'd33, 32'd0);
        send_beat(CMD_UNUSED,    6'd1,  32'hFFFF_FFFF);
        send_beat(CMD_DEL_MID,   6'd0,  32'd0);
        send_beat(CMD_DEL_FIRST, 6'd0,  32'd0);
        send_beat(CMD_DEL_LAST,  6'd0,  32'd0);
        send_beat(CMD_APPEND,    6'd0,  32'd1);
        send_beat(CMD_CLEAR,     6'd0,  32'd0);
        send_beat(CMD_READ,      6'd0,  32'd0);
        send_beat(CMD_APPEND,    6'd0,  32'd55);
        wait_drained();

        sent      = 0;
        phase_num = 0;
        while (sent < RANDOM_ITEMS) begin
            kind      = t_phase_kind'(phase_num % 3);
            phase_len = $urandom_range(40, 80);
            steady    = ($urandom_range(0, 3) == 0);
            if (phase_num == 2) begin
                // Let the result side stall long enough that the input backs up.
                steady       = 1'b1;
                hold_request = 1'b1;
            end
            repeat (phase_len) begin
                cmd = pick_cmd(kind);
                send_beat(cmd, pick_position(cmd, list_len), pick_value());
                sent++;
            end
            if (phase_num % 5 == 4) begin
                wait_drained();
            end
            phase_num++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* positional_insert_delete_list.f */
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/pidl_ctrl.sv
rtl/pidl_obuf.sv
rtl/positional_insert_delete_list.sv
rtl/pidl_checker.sv
sim/pidl_list_checker.sv
sim/tb_positional_insert_delete_list.sv
